// ----- rtl/keyframe_prebuffer_index_defines.svh -----
// assertion macros used by the checker file
`ifndef KEYFRAME_PREBUFFER_INDEX_DEFINES_SVH
`define KEYFRAME_PREBUFFER_INDEX_DEFINES_SVH

// property that must hold on every clock edge outside reset
`define KPI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also holds while reset is asserted
`define KPI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/kpi_pkg.sv -----
`default_nettype none
package kpi_pkg;
    localparam int SlotCount = 64;
    localparam int SlotBits = $clog2(SlotCount);
    localparam int CountBits = SlotBits + 1;
    localparam logic [31:0] RegionReset = 32'd1048576;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_FIND_KEY = 2'd1,
        CMD_FIND_TIME = 2'd2,
        CMD_READ = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_EMPTY = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_BAD_LEN = 3'd3,
        ST_RANGE = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd cmd;
        logic [31:0] frame_length;
        logic [63:0] frame_time;
        logic frame_is_key;
        logic [63:0] wanted_age;
        logic [63:0] earliest_time;
        logic [31:0] slot_number;
    } t_cmd_word;

    typedef struct packed {
        t_status status;
        logic [31:0] frame_index;
        logic [31:0] placed_offset;
        logic [31:0] placed_length;
        logic [63:0] slot_time;
        logic slot_is_key;
    } t_result;

    localparam int CmdWidth = $bits(t_cmd_word);
    localparam int ResWidth = $bits(t_result);
endpackage
`default_nettype wire

// ----- rtl/kpi_ram.sv -----
`default_nettype none
module kpi_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_waddr,
    input  wire [Width-1:0]         i_wdata,
    input  wire [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/kpi_front.sv -----
`default_nettype none
module kpi_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire kpi_pkg::t_cmd_word i_word,
    output logic                 o_q_valid,
    input  wire                  i_q_ready,
    output kpi_pkg::t_cmd_word   o_q_word
);
    import kpi_pkg::*;

    // two-entry queue between accept side and execution side
    t_cmd_word r_buf [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_word = r_buf[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= i_word;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ----- rtl/kpi_back.sv -----
`default_nettype none
module kpi_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [31:0]           i_cfg_data,
    input  wire                  i_q_valid,
    output logic                 o_q_ready,
    input  wire kpi_pkg::t_cmd_word i_q_word,
    output logic                 o_res_valid,
    input  wire                  i_res_ready,
    output kpi_pkg::t_result     o_res
);
    import kpi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PUSH, S_NEWEST, S_SCAN, S_READ, S_OUT
    } t_state;

    t_state r_state;
    t_cmd_word r_cmd;
    logic [31:0] r_region, r_head, r_wc, r_idx, r_best, r_emit;
    logic [CountBits-1:0] r_held, r_k;
    logic [63:0] r_newest;
    logic r_have, r_wait;
    logic [31:0] r_off;

    logic we;
    logic [SlotBits-1:0] waddr, raddr;
    logic [31:0] rd_off, rd_len;
    logic [63:0] rd_time;
    logic [0:0] rd_key;
    logic [31:0] oldest;
    logic [32:0] fit_sum;
    logic [64:0] diff;
    logic age_ok, time_ok;

    assign oldest = r_wc - {{(32-CountBits){1'b0}}, r_held};
    assign fit_sum = {1'b0, r_head} + {1'b0, r_cmd.frame_length};
    assign waddr = r_wc[SlotBits-1:0];
    assign we = (r_state == S_PUSH);

    kpi_ram #(.Width(32), .Depth(SlotCount)) u_off (.i_clk(i_clk), .i_we(we),
        .i_waddr(waddr), .i_wdata(r_off), .i_raddr(raddr), .o_rdata(rd_off));
    kpi_ram #(.Width(32), .Depth(SlotCount)) u_len (.i_clk(i_clk), .i_we(we),
        .i_waddr(waddr), .i_wdata(r_cmd.frame_length), .i_raddr(raddr),
        .o_rdata(rd_len));
    kpi_ram #(.Width(64), .Depth(SlotCount)) u_time (.i_clk(i_clk), .i_we(we),
        .i_waddr(waddr), .i_wdata(r_cmd.frame_time), .i_raddr(raddr),
        .o_rdata(rd_time));
    kpi_ram #(.Width(1), .Depth(SlotCount)) u_key (.i_clk(i_clk), .i_we(we),
        .i_waddr(waddr), .i_wdata(r_cmd.frame_is_key), .i_raddr(raddr),
        .o_rdata(rd_key));

    // read address follows the scan index, or the emit index in S_OUT
    always_comb begin
        case (r_state)
            S_OUT: raddr = r_emit[SlotBits-1:0];
            default: raddr = r_idx[SlotBits-1:0];
        endcase
    end

    // newest - time >= age, exact in 65 bits
    assign diff = {r_newest[63], r_newest} - {rd_time[63], rd_time};
    assign age_ok = $signed(diff) >= $signed({r_cmd.wanted_age[63], r_cmd.wanted_age});
    assign time_ok = $signed(rd_time) >= $signed(r_cmd.earliest_time);

    assign o_q_ready = (r_state == S_IDLE) && !o_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_region <= RegionReset;
            r_head <= '0;
            r_wc <= '0;
            r_held <= '0;
            o_res_valid <= 1'b0;
            r_wait <= 1'b0;
        end else begin
            if (i_cfg_we) r_region <= i_cfg_data;
            if (o_res_valid && i_res_ready) o_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid && o_q_ready) begin
                        r_cmd <= i_q_word;
                        o_res <= '0;
                        r_have <= 1'b0;
                        r_k <= '0;
                        r_wait <= 1'b1;
                        if (i_q_word.cmd == CMD_PUSH) begin
                            if (i_q_word.frame_length == 32'd0 ||
                                i_q_word.frame_length > r_region) begin
                                o_res <= '{status: ST_BAD_LEN, default: '0};
                                o_res_valid <= 1'b1;
                            end else begin
                                r_state <= S_PUSH;
                            end
                        end else if (r_held == '0) begin
                            o_res <= '{status: ST_EMPTY, default: '0};
                            o_res_valid <= 1'b1;
                        end else if (i_q_word.cmd == CMD_FIND_KEY) begin
                            r_idx <= r_wc - 32'd1;
                            r_state <= S_NEWEST;
                        end else if (i_q_word.cmd == CMD_FIND_TIME) begin
                            r_idx <= oldest;
                            r_state <= S_SCAN;
                        end else begin
                            if (i_q_word.slot_number - oldest <
                                {{(32-CountBits){1'b0}}, r_held}) begin
                                r_emit <= i_q_word.slot_number;
                                r_state <= S_OUT;
                            end else begin
                                o_res <= '{status: ST_RANGE, default: '0};
                                o_res_valid <= 1'b1;
                            end
                        end
                    end
                end
                S_PUSH: begin
                    if (r_wait) begin
                        r_off <= fit_sum > {1'b0, r_region} ? 32'd0 : r_head;
                        r_wait <= 1'b0;
                    end else begin
                        r_head <= r_off + r_cmd.frame_length;
                        o_res <= '{status: ST_OK, frame_index: r_wc,
                            placed_offset: r_off, placed_length: r_cmd.frame_length,
                            slot_time: r_cmd.frame_time,
                            slot_is_key: r_cmd.frame_is_key};
                        o_res_valid <= 1'b1;
                        r_wc <= r_wc + 32'd1;
                        if (r_held != CountBits'(SlotCount)) r_held <= r_held + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_NEWEST: begin
                    // present the address, then take the registered read data
                    if (r_wait) begin
                        r_wait <= 1'b0;
                    end else begin
                        r_newest <= rd_time;
                        r_wait <= 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_wait) begin
                        r_wait <= 1'b0;
                    end else begin
                        r_wait <= 1'b1;
                        r_k <= r_k + 1'b1;
                        if (r_cmd.cmd == CMD_FIND_KEY) begin
                            r_idx <= r_idx - 32'd1;
                            if (rd_key[0]) begin
                                r_have <= 1'b1;
                                r_best <= r_idx;
                            end
                            if (rd_key[0] && age_ok) begin
                                r_emit <= r_idx;
                                r_state <= S_OUT;
                            end else if (r_k + 1'b1 == r_held) begin
                                if (rd_key[0] || r_have) begin
                                    r_emit <= rd_key[0] ? r_idx : r_best;
                                    r_state <= S_OUT;
                                end else begin
                                    o_res <= '{status: ST_NOT_FOUND, default: '0};
                                    o_res_valid <= 1'b1;
                                    r_state <= S_IDLE;
                                end
                            end
                        end else begin
                            r_idx <= r_idx + 32'd1;
                            if (time_ok) begin
                                r_emit <= r_idx;
                                r_state <= S_OUT;
                            end else if (r_k + 1'b1 == r_held) begin
                                o_res <= '{status: ST_NOT_FOUND, default: '0};
                                o_res_valid <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                S_OUT: begin
                    if (r_wait) begin
                        r_wait <= 1'b0;
                    end else begin
                        o_res <= '{status: ST_OK, frame_index: r_emit,
                            placed_offset: rd_off, placed_length: rd_len,
                            slot_time: rd_time, slot_is_key: rd_key[0]};
                        o_res_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic unused;
    assign unused = ^{r_cmd.slot_number, S_READ};
endmodule
`default_nettype wire

// ----- rtl/keyframe_prebuffer_index.sv -----
`default_nettype none
// Frame ring index: a two-word input queue feeds a sequencer that owns
// the slot memories; both searches read one slot at a time.
// One command is executed at a time; a result waits in the output
// register while the queue keeps taking words until it is full.
// Rejections give one result with all fields but status zero.
module keyframe_prebuffer_index (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire [31:0]   i_cfg_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // command, frame_length, frame_time, frame_is_key, wanted_age,
    // earliest_time, slot_number; zero pad to 264 bits
    input  wire [263:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // status, frame_index, placed_offset, placed_length, slot_time,
    // slot_is_key; zero pad to 168 bits
    output logic [167:0] m_axis_tdata
);
    import kpi_pkg::*;

    t_cmd_word in_word, q_word;
    t_result res;
    logic q_valid, q_ready;

    assign in_word.cmd = t_cmd'(s_axis_tdata[1:0]);
    assign in_word.frame_length = s_axis_tdata[33:2];
    assign in_word.frame_time = s_axis_tdata[97:34];
    assign in_word.frame_is_key = s_axis_tdata[98];
    assign in_word.wanted_age = s_axis_tdata[162:99];
    assign in_word.earliest_time = s_axis_tdata[226:163];
    assign in_word.slot_number = s_axis_tdata[258:227];

    kpi_front u_front (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_word(in_word), .o_q_valid(q_valid),
        .i_q_ready(q_ready), .o_q_word(q_word));

    kpi_back u_back (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .i_q_valid(q_valid), .o_q_ready(q_ready),
        .i_q_word(q_word), .o_res_valid(m_axis_tvalid),
        .i_res_ready(m_axis_tready), .o_res(res));

    assign m_axis_tdata = {4'd0, res.slot_is_key, res.slot_time, res.placed_length,
        res.placed_offset, res.frame_index, res.status};

    logic unused;
    assign unused = ^s_axis_tdata[263:259];
endmodule
`default_nettype wire

// ----- rtl/kpi_checker.sv -----
`default_nettype none
`include "keyframe_prebuffer_index_defines.svh"
module kpi_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [167:0] m_axis_tdata
);
    import kpi_pkg::*;

    `KPI_ASSERT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output word dropped under stall")
    `KPI_ASSERT(a_status_code, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'(ST_RANGE), "bad status code")
    `KPI_ASSERT(a_fail_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[2:0] != 3'(ST_OK) |-> m_axis_tdata[167:3] == '0, "failed result carries data")
    `KPI_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !m_axis_tvalid && s_axis_tready, "not idle after reset")
endmodule
bind keyframe_prebuffer_index kpi_checker u_kpi_checker (.i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));
`default_nettype wire

// ----- tb/kpi_checker.sv -----
`timescale 1ns / 1ps
module tb_kpi_checker (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire [31:0]   i_cfg_data,
    input  wire          s_axis_tvalid,
    input  wire          s_axis_tready,
    input  wire [263:0]  s_axis_tdata,
    input  wire          m_axis_tvalid,
    input  wire          m_axis_tready,
    input  wire [167:0]  m_axis_tdata,
    output int           o_fail_count,
    output int           o_pending
);
    import kpi_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] index;
        logic [31:0] offset;
        logic [31:0] length;
        logic [63:0] ftime;
        logic        key;
    } t_frame_result;

    logic [31:0] ring_offset [SlotCount];
    logic [31:0] ring_length [SlotCount];
    logic [63:0] ring_time [SlotCount];
    logic        ring_key [SlotCount];
    logic [31:0] wr_count;
    logic [31:0] held;
    logic [31:0] head;
    logic [31:0] region;
    t_frame_result expected_results[$];

    assign o_pending = expected_results.size();

    function automatic logic signed_ge(logic [63:0] a, logic [63:0] b);
        return $signed(a) >= $signed(b);
    endfunction

    // exact (a - b) >= w, done at 66 bits so nothing overflows
    function automatic logic old_enough(logic [63:0] a, logic [63:0] b, logic [63:0] w);
        logic signed [65:0] diff;
        diff = {{2{a[63]}}, a} - {{2{b[63]}}, b};
        return diff >= $signed({{2{w[63]}}, w});
    endfunction

    function automatic t_frame_result slot_result(logic [31:0] logical);
        t_frame_result r;
        int p;
        p = logical % SlotCount;
        r.status = ST_OK;
        r.index = logical;
        r.offset = ring_offset[p];
        r.length = ring_length[p];
        r.ftime = ring_time[p];
        r.key = ring_key[p];
        return r;
    endfunction

    function automatic t_frame_result predict_frame_cmd(logic [263:0] w);
        t_frame_result r;
        logic [1:0]  op;
        logic [31:0] len, off, oldest, logical, best, slot;
        logic [63:0] ftime, age, bound, newest;
        logic        fkey, have;
        op = w[1:0];
        len = w[33:2];
        ftime = w[97:34];
        fkey = w[98];
        age = w[162:99];
        bound = w[226:163];
        slot = w[258:227];
        r = '{default: 0};
        oldest = wr_count - held;
        if (op == CMD_PUSH) begin
            if (len == 0 || len > region) begin
                r.status = ST_BAD_LEN;
                return r;
            end
            off = head;
            if ({1'b0, off} + {1'b0, len} > {1'b0, region}) off = 0;
            head = off + len;
            ring_offset[wr_count % SlotCount] = off;
            ring_length[wr_count % SlotCount] = len;
            ring_time[wr_count % SlotCount] = ftime;
            ring_key[wr_count % SlotCount] = fkey;
            r = slot_result(wr_count);
            wr_count++;
            if (held < SlotCount) held++;
            return r;
        end
        if (held == 0) begin
            r.status = ST_EMPTY;
            return r;
        end
        if (op == CMD_FIND_KEY) begin
            newest = ring_time[(wr_count - 1) % SlotCount];
            have = 0;
            best = 0;
            for (int k = 0; k < held; k++) begin
                logical = wr_count - 1 - k;
                if (!ring_key[logical % SlotCount]) continue;
                best = logical;
                have = 1;
                if (old_enough(newest, ring_time[logical % SlotCount], age)) break;
            end
            if (have) r = slot_result(best);
            else r.status = ST_NOT_FOUND;
            return r;
        end
        if (op == CMD_FIND_TIME) begin
            for (int k = 0; k < held; k++) begin
                logical = oldest + k;
                if (signed_ge(ring_time[logical % SlotCount], bound))
                    return slot_result(logical);
            end
            r.status = ST_NOT_FOUND;
            return r;
        end
        if (slot - oldest < held) r = slot_result(slot);
        else r.status = ST_RANGE;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_frame_result got, want;
        if (!i_rst_n) begin
            wr_count <= 0;
            held <= 0;
            head <= 0;
            region <= RegionReset;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) region = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_frame_cmd(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tdata[2:0];
                got.index = m_axis_tdata[34:3];
                got.offset = m_axis_tdata[66:35];
                got.length = m_axis_tdata[98:67];
                got.ftime = m_axis_tdata[162:99];
                got.key = m_axis_tdata[163];
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result word %h", m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        if (o_fail_count < 10)
                            $display("mismatch exp st=%0d idx=%h off=%h len=%h t=%h k=%b got st=%0d idx=%h off=%h len=%h t=%h k=%b",
                                want.status, want.index, want.offset, want.length, want.ftime,
                                want.key, got.status, got.index, got.offset, got.length,
                                got.ftime, got.key);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/tb_keyframe_prebuffer_index.sv -----
`timescale 1ns / 1ps
module tb_keyframe_prebuffer_index;
    import kpi_pkg::*;

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          i_cfg_we = 0;
    logic [31:0]   i_cfg_data = 0;
    logic          s_axis_tvalid = 0;
    wire           s_axis_tready;
    logic [263:0]  s_axis_tdata = 0;
    wire           m_axis_tvalid;
    logic          m_axis_tready = 0;
    wire  [167:0]  m_axis_tdata;
    int            fail_count;
    int            pending;
    logic          idle_on = 1;
    logic          hold_sink = 0;
    logic [63:0]   time_now = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    keyframe_prebuffer_index u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    tb_kpi_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // sink: random stall bursts while idle_on is set, plus a long hold while hold_sink is set
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_sink) m_axis_tready <= 0;
            else if (idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 8);
                m_axis_tready <= 0;
                repeat (n) @(posedge i_clk);
                m_axis_tready <= 1;
            end else m_axis_tready <= 1;
        end
    end

    // tvalid stays high after a word; the next follows with no gap unless gaps adds one
    task automatic send_word(logic [1:0] op, logic [31:0] len, logic [63:0] ftime,
                             logic key, logic [63:0] age, logic [63:0] bound,
                             logic [31:0] slot, bit gaps);
        int n;
        if (gaps && idle_on && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 8);
            s_axis_tvalid <= 0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {5'd0, slot, bound, age, key, ftime, len, op};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_then_config(logic [31:0] region);
        int guard;
        guard = 0;
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (150) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= region;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic random_word(logic [31:0] region, logic [31:0] base);
        logic [31:0] len;
        int pick;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0: len = 0;
            1: len = region;
            2: len = region + 1;
            3: len = $urandom;
            default: len = $urandom_range(1, (region > 1000) ? region / 5 : region);
        endcase
        time_now = time_now + $urandom_range(0, 40000);
        if (pick < 50)
            send_word(CMD_PUSH, len, ($urandom_range(0, 20) == 0) ? rand64() : time_now,
                      $urandom_range(0, 3) == 0, 0, 0, 0, 1);
        else if (pick < 65)
            send_word(CMD_FIND_KEY, 0, 0, 0,
                      ($urandom_range(0, 5) == 0) ? rand64() : $urandom_range(0, 900000),
                      0, 0, 1);
        else if (pick < 80)
            send_word(CMD_FIND_TIME, 0, 0, 0, 0,
                      ($urandom_range(0, 5) == 0) ? rand64() : time_now - $urandom_range(0, 2000000),
                      0, 1);
        else
            send_word(CMD_READ, 0, 0, 0, 0, 0,
                      ($urandom_range(0, 5) == 0) ? $urandom : base + $urandom_range(0, 80) - 8, 1);
    endtask

    initial begin
        logic [31:0] regions [4];
        regions = '{32'd1, 32'd5000, 32'hFFFF_FFFF, 32'd1048576};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // empty buffer on every search and read, bad lengths
        send_word(CMD_FIND_KEY, 0, 0, 0, 0, 0, 0, 0);
        send_word(CMD_FIND_TIME, 0, 0, 0, 0, 0, 0, 0);
        send_word(CMD_READ, 0, 0, 0, 0, 0, 0, 0);
        send_word(CMD_PUSH, 0, 0, 1, 0, 0, 0, 0);
        send_word(CMD_PUSH, 32'd1048577, 0, 1, 0, 0, 0, 0);
        send_word(CMD_PUSH, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0);
        // non-key push, no keyframe found; key pushes wrap at region tail
        send_word(CMD_PUSH, 32'd1048576, 64'h8000_0000_0000_0000, 0, 0, 0, 0, 0);
        send_word(CMD_FIND_KEY, 0, 0, 0, 0, 0, 0, 0);
        send_word(CMD_PUSH, 32'd600000, 64'h7FFF_FFFF_FFFF_FFFF, 1, 0, 0, 0, 0);
        send_word(CMD_PUSH, 32'd600000, 64'd5, 1, 0, 0, 0, 0);
        // age overflow and time bound extremes, then slot reads in and out of range
        send_word(CMD_FIND_KEY, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0);
        send_word(CMD_FIND_KEY, 0, 0, 0, 64'h8000_0000_0000_0000, 0, 0, 0);
        send_word(CMD_FIND_TIME, 0, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
        send_word(CMD_FIND_TIME, 0, 0, 0, 0, 64'h8000_0000_0000_0000, 0, 0);
        send_word(CMD_FIND_TIME, 0, 0, 0, 0, 64'd6, 0, 0);
        send_word(CMD_READ, 0, 0, 0, 0, 0, 32'd2, 0);
        send_word(CMD_READ, 0, 0, 0, 0, 0, 32'd3, 0);
        send_word(CMD_READ, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);

        // shrink region below the head, then cycle through sizes
        for (int ph = 0; ph < 4; ph++) begin
            drain_then_config(regions[ph]);
            if (ph == 1) begin
                // fill the ring, starting while the sink holds off
                fork
                    begin
                        hold_sink = 1;
                        repeat (400) @(posedge i_clk);
                        hold_sink = 0;
                    end
                    for (int i = 0; i < 70; i++)
                        send_word(CMD_PUSH, $urandom_range(1, 5000), time_now + i * 100,
                                  $urandom_range(0, 1), 0, 0, 0, 0);
                join
            end
            if (ph == 3) idle_on = 0;
            for (int i = 0; i < 120; i++)
                random_word(regions[ph], u_checker.wr_count - 64);
        end

        begin : finish_up
            int guard;
            guard = 0;
            s_axis_tvalid <= 0;
            @(posedge i_clk);
            while (pending != 0 && guard < 300000) begin
                @(posedge i_clk);
                guard++;
            end
            repeat (200) @(posedge i_clk);
        end
        if (fail_count == 0 && pending == 0) $display("PASS keyframe_prebuffer_index");
        else $display("FAIL keyframe_prebuffer_index");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL keyframe_prebuffer_index");
        $finish;
    end
endmodule

// ----- keyframe_prebuffer_index.f -----
+incdir+rtl
rtl/kpi_pkg.sv
rtl/kpi_ram.sv
rtl/kpi_front.sv
rtl/kpi_back.sv
rtl/keyframe_prebuffer_index.sv
rtl/kpi_checker.sv
tb/kpi_checker.sv
tb/tb_keyframe_prebuffer_index.sv
